// ===== sv/mmfe_pkg.sv =====
// Shared types, constants and the CRC16 step for the Modbus motion frame encoder.
// No dependencies; every other file of the block imports this package.
package mmfe_pkg;

  typedef enum logic [1:0] {
    ACT_STOP = 2'd0,
    ACT_HOME = 2'd1,
    ACT_REL  = 2'd2,
    ACT_ABS  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_DEV_ADDR   = 3'd0,
    CFG_MOVE_SPEED = 3'd1,
    CFG_MOVE_ACCEL = 3'd2,
    CFG_MOVE_DECEL = 3'd3,
    CFG_HOME_SPEED = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Queue depths (defaults for the top-level parameters)
  localparam int unsigned DefCmdDepth = 2;
  localparam int unsigned DefOutDepth = 2;

  // Register reset values
  localparam logic [7:0]  RstDevAddr   = 8'h01;
  localparam logic [15:0] RstMoveSpeed = 16'd200;
  localparam logic [15:0] RstMoveAccel = 16'd50;
  localparam logic [15:0] RstMoveDecel = 16'd50;
  localparam logic [15:0] RstHomeSpeed = 16'd300;

  // Modbus codes
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [7:0]  FcWriteSingle = 8'h06;
  localparam logic [7:0]  FcWriteMulti  = 8'h10;
  localparam logic [7:0]  SetupRegHi    = 8'h62;
  localparam logic [7:0]  SetupAbsBit   = 8'h10;
  localparam logic [7:0]  SetupUpBit    = 8'h08;
  localparam logic [7:0]  SetupWordCnt  = 8'h06;
  localparam logic [7:0]  SetupByteCnt  = 8'h0C;
  localparam logic [7:0]  ModeRel       = 8'h41;
  localparam logic [7:0]  ModeAbs       = 8'h01;
  localparam logic [15:0] RegCtrl       = 16'h6002;
  localparam logic [15:0] RegHomeMode   = 16'h600A;
  localparam logic [15:0] RegHomeSpeed  = 16'h600F;
  localparam logic [15:0] CtrlStop      = 16'h0040;
  localparam logic [15:0] CtrlHome      = 16'h0020;
  localparam logic [15:0] HomeModeVal   = 16'h0001;
  localparam logic [7:0]  TrigBase      = 8'h10;
  localparam logic [7:0]  TrigAbsBit    = 8'h02;
  localparam logic [7:0]  TrigUpBit     = 8'h01;

  // Frame geometry: body lengths, last frame indexes
  localparam int unsigned PosW        = 5;
  localparam logic [4:0]  SetupLen    = 5'd19;
  localparam logic [4:0]  SingleLen   = 5'd6;
  localparam logic [1:0]  LastFrStop  = 2'd0;
  localparam logic [1:0]  LastFrHome  = 2'd2;
  localparam logic [1:0]  LastFrMove  = 2'd1;

  typedef struct packed {
    action_e     action;
    logic        up;
    logic [31:0] pulses;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [15:0] move_speed;
    logic [15:0] move_accel;
    logic [15:0] move_decel;
    logic [15:0] home_speed;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
    logic       last;
  } out_item_t;

  // One byte through the reflected CRC16 (eight shift steps)
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/mmfe_front.sv =====
// Front end: accepts commands, normalizes direction, holds them in a short queue.
// Depends on mmfe_pkg.
module mmfe_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action_i,
  input  logic                  move_up_i,
  input  logic signed [31:0]    pulses_i,
  output logic                  cmd_valid_o,
  output mmfe_pkg::cmd_t        cmd_o,
  input  logic                  cmd_pop_i
);
  import mmfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cmd_t            cmd_in;
  logic            do_push, do_pop, is_move;

  // Classify: moves carry a direction; upward negates the pulse count mod 2^32
  always_comb begin
    is_move       = (action_i == ACT_REL) || (action_i == ACT_ABS);
    cmd_in.action = action_e'(action_i);
    cmd_in.up     = is_move & move_up_i;
    cmd_in.pulses = (is_move && move_up_i) ? (32'd0 - pulses_i) : pulses_i;
  end

  assign full        = (cnt_q == CntFull);
  assign do_push     = push & ~full;
  assign cmd_valid_o = (cnt_q != '0);
  assign do_pop      = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== sv/mmfe_back.sv =====
// Back end: walks one command's frames, one byte per unstalled cycle, running CRC16.
// Depends on mmfe_pkg.
module mmfe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mmfe_pkg::cfg_t       cfg_i,
  input  logic                 cmd_valid_i,
  input  mmfe_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  output logic                 item_valid_o,
  output mmfe_pkg::out_item_t  item_o,
  input  logic                 item_ready_i
);
  import mmfe_pkg::*;

  logic [1:0]      frame_q, frame_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;

  logic            is_move, is_abs, setup_fr;
  logic [PosW-1:0] body_len;
  logic [1:0]      last_fr;
  logic            in_body, crc_lo, crc_hi, advance, is_last_fr;
  logic [15:0]     reg_addr, reg_val;
  logic [7:0]      body_byte, trig;

  always_comb begin
    is_move  = (cmd_i.action == ACT_REL) || (cmd_i.action == ACT_ABS);
    is_abs   = (cmd_i.action == ACT_ABS);
    setup_fr = is_move && (frame_q == 2'd0);
    body_len = setup_fr ? SetupLen : SingleLen;
    in_body  = (pos_q < body_len);
    crc_lo   = (pos_q == body_len);
    crc_hi   = (pos_q == body_len + 1'b1);
    trig     = TrigBase | (is_abs ? TrigAbsBit : 8'h00) | (cmd_i.up ? TrigUpBit : 8'h00);
  end

  // Register and value of a single-register write frame
  always_comb begin
    reg_addr = RegCtrl;
    reg_val  = CtrlStop;
    last_fr  = LastFrStop;
    unique case (cmd_i.action)
      ACT_STOP: begin
        reg_addr = RegCtrl;
        reg_val  = CtrlStop;
        last_fr  = LastFrStop;
      end
      ACT_HOME: begin
        last_fr = LastFrHome;
        if (frame_q == 2'd0) begin
          reg_addr = RegHomeMode;
          reg_val  = HomeModeVal;
        end else if (frame_q == 2'd1) begin
          reg_addr = RegHomeSpeed;
          reg_val  = cfg_i.home_speed;
        end else begin
          reg_addr = RegCtrl;
          reg_val  = CtrlHome;
        end
      end
      default: begin
        reg_addr = RegCtrl;
        reg_val  = {8'h00, trig};
        last_fr  = LastFrMove;
      end
    endcase
    is_last_fr = (frame_q == last_fr);
  end

  // Body byte at the current position
  always_comb begin
    body_byte = 8'h00;
    if (setup_fr) begin
      unique case (pos_q)
        5'd0:    body_byte = cfg_i.dev_addr;
        5'd1:    body_byte = FcWriteMulti;
        5'd2:    body_byte = SetupRegHi;
        5'd3:    body_byte = (is_abs ? SetupAbsBit : 8'h00) | (cmd_i.up ? SetupUpBit : 8'h00);
        5'd4:    body_byte = 8'h00;
        5'd5:    body_byte = SetupWordCnt;
        5'd6:    body_byte = SetupByteCnt;
        5'd7:    body_byte = 8'h00;
        5'd8:    body_byte = is_abs ? ModeAbs : ModeRel;
        5'd9:    body_byte = cmd_i.pulses[31:24];
        5'd10:   body_byte = cmd_i.pulses[23:16];
        5'd11:   body_byte = cmd_i.pulses[15:8];
        5'd12:   body_byte = cmd_i.pulses[7:0];
        5'd13:   body_byte = cfg_i.move_speed[15:8];
        5'd14:   body_byte = cfg_i.move_speed[7:0];
        5'd15:   body_byte = cfg_i.move_accel[15:8];
        5'd16:   body_byte = cfg_i.move_accel[7:0];
        5'd17:   body_byte = cfg_i.move_decel[15:8];
        5'd18:   body_byte = cfg_i.move_decel[7:0];
        default: body_byte = 8'h00;
      endcase
    end else begin
      unique case (pos_q)
        5'd0:    body_byte = cfg_i.dev_addr;
        5'd1:    body_byte = FcWriteSingle;
        5'd2:    body_byte = reg_addr[15:8];
        5'd3:    body_byte = reg_addr[7:0];
        5'd4:    body_byte = reg_val[15:8];
        5'd5:    body_byte = reg_val[7:0];
        default: body_byte = 8'h00;
      endcase
    end
  end

  assign advance      = cmd_valid_i & item_ready_i;
  assign item_valid_o = cmd_valid_i;
  assign cmd_pop_o    = advance & crc_hi & is_last_fr;

  always_comb begin
    item_o.frame_byte   = in_body ? body_byte : (crc_lo ? crc_q[7:0] : crc_q[15:8]);
    item_o.end_of_frame = crc_hi;
    item_o.last         = crc_hi & is_last_fr;
  end

  always_comb begin
    frame_d = frame_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    if (advance) begin
      if (crc_hi) begin
        pos_d   = '0;
        crc_d   = CrcInit;
        frame_d = is_last_fr ? 2'd0 : frame_q + 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
        if (in_body) begin
          crc_d = crc16_byte(crc_q, body_byte);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      pos_q   <= '0;
      crc_q   <= CrcInit;
    end else begin
      frame_q <= frame_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
    end
  end

endmodule

// ===== sv/mmfe_outq.sv =====
// Result queue between the byte sequencer and the result port.
// Depends on mmfe_pkg.
module mmfe_outq #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  mmfe_pkg::out_item_t  item_i,
  output logic                 item_ready_o,
  output logic                 empty,
  input  logic                 pop,
  output mmfe_pkg::out_item_t  item_o
);
  import mmfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  out_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  // A pop in the same cycle frees a slot
  assign empty        = (cnt_q == '0);
  assign do_pop       = pop & ~empty;
  assign item_ready_o = (cnt_q != CntFull) | do_pop;
  assign do_push      = item_valid_i & item_ready_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/modbus_motion_frame_encoder_top.sv =====
// Modbus RTU motion frame encoder, top level: config registers and the three stages.
// Depends on mmfe_pkg, mmfe_front, mmfe_back, mmfe_outq.
//
// Usage:
//   Command side is a queue input: drive action_i/move_up_i/pulses_i and raise push;
//   an item is taken on a clock edge with push high and full low.
//   Result side is a queue output: while empty is low the oldest byte sits on
//   frame_byte_o/end_of_frame_o/last_o and leaves on an edge with pop high.
//   Each command yields a stream of Modbus RTU frames, each closed by CRC16
//   (low byte, then high byte with end_of_frame_o set); last_o marks the final
//   byte of the command: 8 bytes for stop, 24 for home, 29 for a move.
// Timing:
//   The byte sequencer emits one byte per cycle while the result queue has room and
//   stays on a command until its last byte is taken. The first byte passes through
//   the command queue and the result queue registers on its way to the result ports.
//   The command queue (CmdDepth) takes new items while the sequencer works, so with
//   pop held high and commands waiting the output runs at one byte per cycle.
// Stalls and reset:
//   When pop stays low the result queue fills, the sequencer holds its place and
//   the command queue backs up until full rises; nothing is dropped.
//   Reset empties both queues, restarts the sequencer and loads the register
//   defaults (address 1, speed 200, accel 50, decel 50, home speed 300).
//   Register writes (cfg_we_i) take effect next cycle; write only while idle.
module modbus_motion_frame_encoder_top #(
  parameter int unsigned CmdDepth = mmfe_pkg::DefCmdDepth,
  parameter int unsigned OutDepth = mmfe_pkg::DefOutDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mmfe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mmfe_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action_i,
  input  logic                           move_up_i,
  input  logic signed [31:0]             pulses_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     frame_byte_o,
  output logic                           end_of_frame_o,
  output logic                           last_o
);
  import mmfe_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      cmd_valid, cmd_pop;
  cmd_t      cmd;
  logic      item_valid, item_ready;
  out_item_t item_seq, item_out;

  // Config registers; indexes past the list are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEV_ADDR:   cfg_d.dev_addr   = cfg_data_i[7:0];
        CFG_MOVE_SPEED: cfg_d.move_speed = cfg_data_i;
        CFG_MOVE_ACCEL: cfg_d.move_accel = cfg_data_i;
        CFG_MOVE_DECEL: cfg_d.move_decel = cfg_data_i;
        CFG_HOME_SPEED: cfg_d.home_speed = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr   <= RstDevAddr;
      cfg_q.move_speed <= RstMoveSpeed;
      cfg_q.move_accel <= RstMoveAccel;
      cfg_q.move_decel <= RstMoveDecel;
      cfg_q.home_speed <= RstHomeSpeed;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: take and normalize commands
  mmfe_front #(
    .Depth (CmdDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .move_up_i   (move_up_i),
    .pulses_i    (pulses_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: byte sequencer with running CRC
  mmfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .item_valid_o (item_valid),
    .item_o       (item_seq),
    .item_ready_i (item_ready)
  );

  // Result queue decouples the sequencer from the consumer
  mmfe_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item_seq),
    .item_ready_o (item_ready),
    .empty        (empty),
    .pop          (pop),
    .item_o       (item_out)
  );

  assign frame_byte_o   = item_out.frame_byte;
  assign end_of_frame_o = item_out.end_of_frame;
  assign last_o         = item_out.last;

endmodule
